@@ rtl/core/lcdenc_pkg.sv @@
`default_nettype none
package lcdenc_pkg;

  localparam int unsigned STEP_W = 4;
  localparam logic [6:0] SECOND_LINE_RESET = 7'h40;

  typedef enum logic [2:0] {
    KIND_INIT = 3'd0,
    KIND_DATA = 3'd1,
    KIND_CMD  = 3'd2,
    KIND_BS   = 3'd3,
    KIND_TAB  = 3'd4
  } kind_e;

  localparam logic [7:0] CHR_STX  = 8'h02;
  localparam logic [7:0] CHR_BS   = 8'h08;
  localparam logic [7:0] CHR_TAB  = 8'h09;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_DEL  = 8'h7F;
  localparam logic [7:0] CHR_CTRL_MAX = 8'h1F;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_SHIFT_R   = 8'h14;
  localparam logic [7:0] CMD_CURSOR_R  = 8'h10;
  localparam logic [7:0] CHR_SPACE     = 8'h20;

  localparam logic [3:0] INIT_LAST = 4'd11;
  localparam logic [3:0] BS_LAST   = 4'd5;
  localparam logic [3:0] TAB_LAST  = 4'd7;
  localparam logic [3:0] BYTE_LAST = 4'd1;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] cmd_byte;
  } entry_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } beat_t;

  // nibble write number 'step' of the run that 'e' stands for
  function automatic beat_t beat_lookup(entry_t e, logic [STEP_W-1:0] step);
    beat_t      b;
    logic [7:0] bv;
    bv = e.cmd_byte;
    b.reg_select = 1'b0;
    b.last = 1'b0;
    case (e.kind)
      KIND_INIT: begin
        b.last = (step == INIT_LAST);
        case (step)
          4'd0, 4'd1, 4'd2: bv = 8'h33;
          4'd3:             bv = 8'h22;
          4'd4, 4'd5:       bv = 8'h08;
          4'd6, 4'd7:       bv = CMD_CLEAR;
          4'd8, 4'd9:       bv = 8'h0F;
          default:          bv = 8'h06;
        endcase
      end
      KIND_DATA: begin
        b.reg_select = 1'b1;
        b.last = (step == BYTE_LAST);
      end
      KIND_BS: begin
        b.last = (step == BS_LAST);
        if (step[3:1] == 3'd1) begin
          bv = CHR_SPACE;
          b.reg_select = 1'b1;
        end else begin
          bv = CMD_SHIFT_R;
        end
      end
      KIND_TAB: begin
        b.last = (step == TAB_LAST);
        bv = CMD_CURSOR_R;
      end
      default: begin
        b.last = (step == BYTE_LAST);
      end
    endcase
    // high nibble on even steps
    b.nibble = step[0] ? bv[3:0] : bv[7:4];
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lcdenc_front.sv @@
`default_nettype none
module lcdenc_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic                op_i,
  input  wire logic [7:0]          char_code_i,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [6:0]          cfg_data_i,
  output      logic                push_o,
  output      lcdenc_pkg::entry_t  push_entry_o,
  input  wire logic                full_i
);
  import lcdenc_pkg::*;

  logic [6:0] line2_addr_q;
  logic       has_run;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line2_addr_q <= SECOND_LINE_RESET;
    end else if (cfg_valid_i) begin
      line2_addr_q <= cfg_data_i;
    end
  end

  always_comb begin
    has_run = 1'b1;
    push_entry_o.kind = KIND_DATA;
    push_entry_o.cmd_byte = char_code_i;
    if (op_i) begin
      push_entry_o.kind = KIND_INIT;
    end else begin
      case (char_code_i) inside
        CHR_STX: begin
          push_entry_o.kind = KIND_CMD;
          push_entry_o.cmd_byte = CMD_CLEAR;
        end
        CHR_BS:  push_entry_o.kind = KIND_BS;
        CHR_TAB: push_entry_o.kind = KIND_TAB;
        CHR_LF: begin
          push_entry_o.kind = KIND_CMD;
          push_entry_o.cmd_byte = CMD_SET_DDRAM | {1'b0, line2_addr_q};
        end
        CHR_CR: begin
          push_entry_o.kind = KIND_CMD;
          push_entry_o.cmd_byte = CMD_HOME;
        end
        [8'h00:CHR_CTRL_MAX], CHR_DEL: has_run = 1'b0;
        default: has_run = 1'b1;
      endcase
    end
  end

  // items that cause no bus writes are taken and dropped here
  assign in_ready_o = !full_i;
  assign push_o = in_valid_i && !full_i && has_run;

endmodule
`default_nettype wire

@@ rtl/core/lcdenc_queue.sv @@
`default_nettype none
module lcdenc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire lcdenc_pkg::entry_t  push_entry_i,
  output      logic                full_o,
  input  wire logic                pop_i,
  output      logic                head_valid_o,
  output      lcdenc_pkg::entry_t  head_o
);
  import lcdenc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_MAX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  entry_t        slots_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign full_o = (count_q == CNT_MAX);
  assign head_valid_o = (count_q != '0);
  assign head_o = slots_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX) else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow push");

endmodule
`default_nettype wire

@@ rtl/core/lcdenc_back.sv @@
`default_nettype none
module lcdenc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  wire lcdenc_pkg::entry_t  head_i,
  output      logic                pop_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic                reg_select_o,
  output      logic [3:0]          nibble_o,
  output      logic                last_o
);
  import lcdenc_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  beat_t             beat_q, beat;
  logic              load;

  assign beat = beat_lookup(head_i, step_q);
  assign load = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && beat.last;

  always_comb begin
    step_d = step_q;
    if (pop_o) begin
      step_d = '0;
    end else if (load) begin
      step_d = step_q + 1'b1;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reg_select_o = beat_q.reg_select;
  assign nibble_o = beat_q.nibble;
  assign last_o = beat_q.last;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= INIT_LAST) else $error("sequencer step out of range");
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (step_q == '0)) else $error("step left over with empty queue");
  a_pop_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == '0)) else $error("step not cleared after run");

endmodule
`default_nettype wire

@@ rtl/core/char_lcd_nibble_command_encoder.sv @@
// An item's first nibble write passes the queue, then the registered output stage.
// Throughput: one nibble write per cycle while out_ready_i is high and an item is queued;
//   an item has 2 to 12 writes (init 12), set by the single-step nibble sequencer.
// Items that cause no writes are taken and dropped while the queue is not full.
// Reset clears the queue, the sequencer and the output valid, and sets the
//   second-line address to 0x40.
`default_nettype none
module char_lcd_nibble_command_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] char_code_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       reg_select_o,
  output      logic [3:0] nibble_o,
  output      logic       last_o,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [6:0] cfg_data_i
);
  import lcdenc_pkg::*;

  logic   push, pop, full, head_valid;
  entry_t push_entry, head;

  lcdenc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  lcdenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lcdenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reg_select_o (reg_select_o),
    .nibble_o     (nibble_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

@@ dv/char_lcd_nibble_command_encoder_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module char_lcd_nibble_command_encoder_test;
  import lcdenc_pkg::*;

  localparam bit OP_CHAR = 1'b0;
  localparam bit OP_INIT = 1'b1;
  localparam int PAUSE_CYCLES = 8;
  localparam int STALL_LIMIT = 3000;
  localparam int RUNS_PER_PHASE = 11;

  // directed row: typed rows carry up to two expected writes, others use the predictor
  typedef struct packed {
    logic       op;
    logic [7:0] code;
    logic       typed;
    logic [1:0] cnt;
    beat_t      hi;
    beat_t      lo;
  } row_t;

  localparam beat_t NONE = '{1'b0, 4'h0, 1'b0};
  localparam int DIR_N = 20;
  localparam row_t DIR_TAB [DIR_N] = '{
    '{OP_INIT, 8'h00, 1'b0, 2'd0, NONE, NONE},
    '{OP_INIT, 8'hFF, 1'b0, 2'd0, NONE, NONE},
    '{OP_CHAR, 8'h00, 1'b1, 2'd0, NONE, NONE},
    '{OP_CHAR, CHR_CTRL_MAX, 1'b1, 2'd0, NONE, NONE},
    '{OP_CHAR, 8'h01, 1'b1, 2'd0, NONE, NONE},
    '{OP_CHAR, 8'h03, 1'b1, 2'd0, NONE, NONE},
    '{OP_CHAR, 8'h0B, 1'b1, 2'd0, NONE, NONE},
    '{OP_CHAR, 8'h0E, 1'b1, 2'd0, NONE, NONE},
    '{OP_CHAR, CHR_DEL, 1'b1, 2'd0, NONE, NONE},
    '{OP_CHAR, CHR_SPACE, 1'b1, 2'd2, '{1'b1, 4'h2, 1'b0}, '{1'b1, 4'h0, 1'b1}},
    '{OP_CHAR, 8'h7E, 1'b1, 2'd2, '{1'b1, 4'h7, 1'b0}, '{1'b1, 4'hE, 1'b1}},
    '{OP_CHAR, 8'h80, 1'b1, 2'd2, '{1'b1, 4'h8, 1'b0}, '{1'b1, 4'h0, 1'b1}},
    '{OP_CHAR, 8'hFF, 1'b1, 2'd2, '{1'b1, 4'hF, 1'b0}, '{1'b1, 4'hF, 1'b1}},
    '{OP_CHAR, 8'h55, 1'b1, 2'd2, '{1'b1, 4'h5, 1'b0}, '{1'b1, 4'h5, 1'b1}},
    '{OP_CHAR, 8'hAA, 1'b1, 2'd2, '{1'b1, 4'hA, 1'b0}, '{1'b1, 4'hA, 1'b1}},
    '{OP_CHAR, CHR_STX, 1'b1, 2'd2, '{1'b0, 4'h0, 1'b0}, '{1'b0, 4'h1, 1'b1}},
    '{OP_CHAR, CHR_CR, 1'b1, 2'd2, '{1'b0, 4'h0, 1'b0}, '{1'b0, 4'h2, 1'b1}},
    '{OP_CHAR, CHR_BS, 1'b0, 2'd0, NONE, NONE},
    '{OP_CHAR, CHR_TAB, 1'b0, 2'd0, NONE, NONE},
    '{OP_CHAR, CHR_LF, 1'b0, 2'd0, NONE, NONE}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = 1'b0;
  logic [7:0] code = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = 7'h00;

  // side info for the item on the input port
  logic       cur_typed = 1'b0;
  logic [1:0] cur_cnt = 2'd0;
  beat_t      cur_hi = NONE;
  beat_t      cur_lo = NONE;

  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic [6:0] line2_addr = SECOND_LINE_RESET;
  beat_t      pending_writes[$];
  int         runs_done = 0;
  int         err_cnt = 0;
  int         stall_cnt = 0;

  char_lcd_nibble_command_encoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .char_code_i  (code),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .reg_select_o (reg_select),
    .nibble_o     (nibble),
    .last_o       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_nibble(bit rs, logic [3:0] nib);
    pending_writes.push_back('{rs, nib, 1'b0});
  endfunction

  function automatic void push_byte(bit rs, logic [7:0] b);
    push_nibble(rs, b[7:4]);
    push_nibble(rs, b[3:0]);
  endfunction

  // expected bus writes for one item; returns how many
  function automatic int encode_char(bit is_init, logic [7:0] ch);
    int n0;
    n0 = pending_writes.size();
    if (is_init) begin
      push_nibble(1'b0, 4'h3);
      push_nibble(1'b0, 4'h3);
      push_nibble(1'b0, 4'h3);
      push_nibble(1'b0, 4'h2);
      push_byte(1'b0, 8'h08);
      push_byte(1'b0, CMD_CLEAR);
      push_byte(1'b0, 8'h0F);
      push_byte(1'b0, 8'h06);
    end else if (ch <= CHR_CTRL_MAX || ch == CHR_DEL) begin
      case (ch)
        CHR_STX: push_byte(1'b0, CMD_CLEAR);
        CHR_BS: begin
          push_byte(1'b0, CMD_SHIFT_R);
          push_byte(1'b1, CHR_SPACE);
          push_byte(1'b0, CMD_SHIFT_R);
        end
        CHR_TAB: begin
          repeat (4) push_byte(1'b0, CMD_CURSOR_R);
        end
        CHR_LF: push_byte(1'b0, CMD_SET_DDRAM | {1'b0, line2_addr});
        CHR_CR: push_byte(1'b0, CMD_HOME);
        default: ;
      endcase
    end else begin
      push_byte(1'b1, ch);
    end
    if (pending_writes.size() > n0) pending_writes[pending_writes.size() - 1].last = 1'b1;
    return pending_writes.size() - n0;
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    int    n;
    bit    moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        line2_addr = cfg_data;
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        if (cur_typed) begin
          n = int'(cur_cnt);
          if (cur_cnt != 2'd0) begin
            pending_writes.push_back(cur_hi);
            pending_writes.push_back(cur_lo);
          end
        end else begin
          n = encode_char(op, code);
        end
        if (n > 0) runs_done++;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        got = '{reg_select, nibble, last};
        if (pending_writes.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected write: rs=%0d nibble=%h last=%0d", reg_select, nibble, last);
          err_cnt++;
        end else begin
          want = pending_writes.pop_front();
          if (got !== want) begin
            if (err_cnt < 10)
              $display("mismatch: want rs=%0d nib=%h last=%0d, got rs=%0d nib=%h last=%0d",
                       want.reg_select, want.nibble, want.last, reg_select, nibble, last);
            err_cnt++;
          end
        end
      end
      stall_cnt = moved ? 0 : stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("** char_lcd_nibble_command_encoder: FAILED **");
        $finish;
      end
    end
  end

  // valid stays up across back-to-back items; gaps only before a new item
  task automatic send_item(bit is_init, logic [7:0] ch, row_t r);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = is_init;
    code = ch;
    cur_typed = r.typed;
    cur_cnt = r.cnt;
    cur_hi = r.hi;
    cur_lo = r.lo;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    logic [7:0] ch;
    bit         is_init;
    int         pick;
    pick = $urandom_range(99);
    is_init = (pick < 8);
    ch = 8'($urandom_range(255));
    if (pick >= 8 && pick < 30) begin
      ch = 8'($urandom_range(31));
    end else if (pick >= 30 && pick < 45) begin
      case ($urandom_range(4))
        0: ch = CHR_STX;
        1: ch = CHR_BS;
        2: ch = CHR_TAB;
        3: ch = CHR_LF;
        default: ch = CHR_CR;
      endcase
    end else if (pick >= 45 && pick < 50) begin
      ch = CHR_DEL;
    end else if (pick >= 50) begin
      ch = 8'($urandom_range(255, 32));
    end
    send_item(is_init, ch, '0);
  endtask

  // register writes only with the block drained
  task automatic drain_and_write(logic [6:0] addr);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (PAUSE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = addr;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [6:0] addr_set [6];
    int         start;
    addr_set = '{7'h00, 7'h7F, 7'($urandom_range(127)), 7'h40,
                 7'($urandom_range(127)), 7'($urandom_range(127))};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 35;
    rx_idle_pct = 73;
    for (int i = 0; i < DIR_N; i++) send_item(DIR_TAB[i].op, DIR_TAB[i].code, DIR_TAB[i]);

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write(addr_set[ph]);
      tx_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 73 : 0;
      rx_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 35 : 0;
      // a line feed up front so every address setting is seen
      send_item(OP_CHAR, CHR_LF, '0);
      start = runs_done;
      while (runs_done - start < RUNS_PER_PHASE) send_random();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (PAUSE_CYCLES) @(negedge clk);
    if (err_cnt == 0 && pending_writes.size() == 0) begin
      $display("** char_lcd_nibble_command_encoder: PASSED **");
    end else begin
      $display("** char_lcd_nibble_command_encoder: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
